// ----- src/wtwd_pkg.sv -----
package wtwd_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int WORKER_COUNT = 8;
    localparam int WORK_ID_BITS = 8;

    localparam int CMD_W    = 2;
    localparam int WORK_W   = 8;
    localparam int WORKER_W = 3;
    localparam int EVENT_W  = 4;
    localparam int PEND_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDLE_W   = $clog2(WORKER_COUNT + 1);
    localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SIDX_W   = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;

    localparam logic [WORK_W-1:0] WORK_MASK = {WORK_W{1'b1}} >> (WORK_W - WORK_ID_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_RETRACT  = 2'd1,
        CMD_RETURN   = 2'd2,
        CMD_SHUTDOWN = 2'd3
    } cmd_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_DISPATCHED = 4'd0,
        EV_QUEUED     = 4'd1,
        EV_REJECTED   = 4'd2,
        EV_ABANDONED  = 4'd3,
        EV_RETRACTED  = 4'd4,
        EV_REFUSED    = 4'd5,
        EV_ASSIGNED   = 4'd6,
        EV_PARKED     = 4'd7,
        EV_DISMISSED  = 4'd8,
        EV_KILLED     = 4'd9,
        EV_SHUT_DONE  = 4'd10
    } ev_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                is_add;
        logic                is_retract;
        logic                is_return;
        logic                is_shutdown;
        logic [WORK_W-1:0]   work;
        logic [WORKER_W-1:0] worker;
    } req_t;

endpackage

// ----- src/wtwd_front.sv -----
module wtwd_front
    import wtwd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [WORK_W-1:0]   s_work_id,
    input  logic [WORKER_W-1:0] s_worker_id,
    output logic                rq_valid,
    input  logic                rq_ready,
    output req_t                rq_data
);

    req_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    req_t       req_in;
    logic       push, pop;

    // decode the command into one-hot class bits
    always_comb begin
        req_in             = '0;
        req_in.work        = s_work_id & WORK_MASK;
        req_in.worker      = s_worker_id;
        case (cmd_t'(s_command))
            CMD_ADD:      req_in.is_add      = 1'b1;
            CMD_RETRACT:  req_in.is_retract  = 1'b1;
            CMD_RETURN:   req_in.is_return   = 1'b1;
            CMD_SHUTDOWN: req_in.is_shutdown = 1'b1;
            default:      req_in.is_shutdown = 1'b1;
        endcase
    end

    assign s_ready  = (count_reg != 2'd2);
    assign rq_valid = (count_reg != 2'd0);
    assign rq_data  = entry_reg[rd_ptr_reg];
    assign push     = s_valid && s_ready;
    assign pop      = rq_valid && rq_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= req_in;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("request queue count out of range");

    a_one_class: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> $onehot({entry_reg[$past(wr_ptr_reg)].is_add,
                          entry_reg[$past(wr_ptr_reg)].is_retract,
                          entry_reg[$past(wr_ptr_reg)].is_return,
                          entry_reg[$past(wr_ptr_reg)].is_shutdown}))
        else $error("stored request has no single class");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |=> (count_reg != 2'd2))
        else $error("request queue jumped from empty to full");

endmodule

// ----- src/wtwd_back.sv -----
module wtwd_back
    import wtwd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rq_valid,
    output logic                rq_ready,
    input  req_t                rq_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [EVENT_W-1:0]  m_event_res,
    output logic [WORK_W-1:0]   m_work_out,
    output logic [WORKER_W-1:0] m_worker_out,
    output logic [PEND_W-1:0]   m_pending_count,
    output logic [IDLE_W-1:0]   m_idle_count,
    output logic                m_last
);

    typedef enum logic [3:0] {
        ST_EXEC    = 4'b0001,
        ST_ABANDON = 4'b0010,
        ST_KILL    = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [WORK_W-1:0]   fifo_reg [QUEUE_DEPTH];
    logic [WORKER_W-1:0] stack_reg [WORKER_COUNT];
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [IDLE_W-1:0]   idle_reg, idle_next;
    logic [IDLE_W-1:0]   kill_reg, kill_next;
    logic                shut_reg, shut_next;

    logic                m_valid_reg, m_valid_next;
    ev_t                 ev_reg, ev_next;
    logic [WORK_W-1:0]   work_reg, work_next;
    logic [WORKER_W-1:0] worker_reg, worker_next;
    logic [PEND_W-1:0]   pcnt_reg, pcnt_next;
    logic [IDLE_W-1:0]   icnt_reg, icnt_next;
    logic                last_reg, last_next;

    logic                   out_free, take, load;
    logic [QUEUE_DEPTH-1:0] match, first, keep_mask, keep_sel;
    logic                   fifo_shift, q_write, s_write;
    logic [SIDX_W-1:0]      rd_idx;
    logic [WORKER_W-1:0]    stack_rd;

    assign out_free = !m_valid_reg || m_ready;
    assign rq_ready = (state_reg == ST_EXEC) && out_free;
    assign take     = rq_valid && rq_ready;

    // parallel compare of the retract id against the live queue entries
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = (fifo_reg[i] == rq_data.work) && (PEND_W'(i) < pend_reg);
        end
        first     = match & (~match + 1'b1);
        keep_mask = first - 1'b1;
    end

    // one stack read port: top for dispatch, bottom-up walk for kill
    assign rd_idx   = (state_reg == ST_KILL) ? kill_reg[SIDX_W-1:0]
                                             : SIDX_W'(idle_reg - 1'b1);
    assign stack_rd = stack_reg[rd_idx];

    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        idle_next   = idle_reg;
        kill_next   = kill_reg;
        shut_next   = shut_reg;
        fifo_shift  = 1'b0;
        keep_sel    = '0;
        q_write     = 1'b0;
        s_write     = 1'b0;
        load        = 1'b0;
        ev_next     = EV_DISPATCHED;
        work_next   = '0;
        worker_next = '0;
        last_next   = 1'b1;
        pcnt_next   = '0;
        icnt_next   = '0;
        case (state_reg)
            ST_EXEC: begin
                if (take) begin
                    if (rq_data.is_shutdown) begin
                        shut_next  = 1'b1;
                        kill_next  = '0;
                        state_next = ST_ABANDON;
                    end else begin
                        load = 1'b1;
                        if (rq_data.is_add) begin
                            work_next = rq_data.work;
                            if (shut_reg) begin
                                ev_next = EV_ABANDONED;
                            end else if (idle_reg != '0) begin
                                ev_next     = EV_DISPATCHED;
                                worker_next = stack_rd;
                                idle_next   = idle_reg - 1'b1;
                            end else if (pend_reg < PEND_W'(QUEUE_DEPTH)) begin
                                ev_next   = EV_QUEUED;
                                q_write   = 1'b1;
                                pend_next = pend_reg + 1'b1;
                            end else begin
                                ev_next = EV_REJECTED;
                            end
                        end else if (rq_data.is_retract) begin
                            work_next = rq_data.work;
                            if (!shut_reg && (first != '0)) begin
                                ev_next    = EV_RETRACTED;
                                fifo_shift = 1'b1;
                                keep_sel   = keep_mask;
                                pend_next  = pend_reg - 1'b1;
                            end else begin
                                ev_next = EV_REFUSED;
                            end
                        end else begin
                            worker_next = rq_data.worker;
                            if (shut_reg) begin
                                ev_next = EV_DISMISSED;
                            end else if (pend_reg != '0) begin
                                ev_next    = EV_ASSIGNED;
                                work_next  = fifo_reg[0];
                                fifo_shift = 1'b1;
                                pend_next  = pend_reg - 1'b1;
                            end else if (idle_reg < IDLE_W'(WORKER_COUNT)) begin
                                ev_next   = EV_PARKED;
                                s_write   = 1'b1;
                                idle_next = idle_reg + 1'b1;
                            end else begin
                                ev_next = EV_DISMISSED;
                            end
                        end
                        pcnt_next = pend_next;
                        icnt_next = idle_next;
                    end
                end
            end
            ST_ABANDON: begin
                if (pend_reg == '0) begin
                    state_next = ST_KILL;
                end else if (out_free) begin
                    load       = 1'b1;
                    ev_next    = EV_ABANDONED;
                    work_next  = fifo_reg[0];
                    last_next  = 1'b0;
                    fifo_shift = 1'b1;
                    pend_next  = pend_reg - 1'b1;
                end
            end
            ST_KILL: begin
                if (kill_reg == idle_reg) begin
                    idle_next  = '0;
                    kill_next  = '0;
                    state_next = ST_DONE;
                end else if (out_free) begin
                    load        = 1'b1;
                    ev_next     = EV_KILLED;
                    worker_next = stack_rd;
                    last_next   = 1'b0;
                    kill_next   = kill_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load       = 1'b1;
                    ev_next    = EV_SHUT_DONE;
                    state_next = ST_EXEC;
                end
            end
            default: begin
                state_next = ST_EXEC;
            end
        endcase
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_EXEC;
            pend_reg    <= '0;
            idle_reg    <= '0;
            kill_reg    <= '0;
            shut_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            idle_reg    <= idle_next;
            kill_reg    <= kill_next;
            shut_reg    <= shut_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ev_reg     <= ev_next;
            work_reg   <= work_next;
            worker_reg <= worker_next;
            pcnt_reg   <= pcnt_next;
            icnt_reg   <= icnt_next;
            last_reg   <= last_next;
        end
    end

    // pending queue: shift toward the head, append at the tail
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (fifo_shift && !keep_sel[i]) begin
                fifo_reg[i] <= fifo_reg[i + 1];
            end
        end
        if (q_write) begin
            fifo_reg[pend_reg[QIDX_W-1:0]] <= rq_data.work;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_write) begin
            stack_reg[idle_reg[SIDX_W-1:0]] <= rq_data.worker;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = ev_reg;
    assign m_work_out      = work_reg;
    assign m_worker_out    = worker_reg;
    assign m_pending_count = pcnt_reg;
    assign m_idle_count    = icnt_reg;
    assign m_last          = last_reg;

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_W'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_idle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg <= IDLE_W'(WORKER_COUNT))
        else $error("idle count above worker count");

    a_shut_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        shut_reg |=> shut_reg)
        else $error("shutdown flag cleared without reset");

    a_drain_shut: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EXEC) |-> shut_reg)
        else $error("drain sequence running without shutdown");

    a_pop_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        rq_ready |-> (state_reg == ST_EXEC))
        else $error("request taken during drain");

endmodule

// ----- src/work_to_worker_dispatcher.sv -----
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_command, s_work_id, s_worker_id
// m_        out        m_valid / m_ready  m_event_res, m_work_out, m_worker_out,
//                                         m_pending_count, m_idle_count, m_last
//
// an accepted request reaches the back end through a two-entry queue; the back end
// takes it in the exec state once its result register is free and loads its result
// there for m_, so it takes one request per cycle while the result register drains and no
// shutdown drain runs. shutdown holds the back end: it takes the request, abandons each
// queued work, then kills each idle worker, ending each walk, and reports shut-done.
// aresetn is synchronous, active low; it clears counts, shutdown flag and valids.
// a stalled m_ holds the back end; s_ready drops only when the queue is full.
module work_to_worker_dispatcher
    import wtwd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [WORK_W-1:0]   s_work_id,
    input  logic [WORKER_W-1:0] s_worker_id,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [EVENT_W-1:0]  m_event_res,
    output logic [WORK_W-1:0]   m_work_out,
    output logic [WORKER_W-1:0] m_worker_out,
    output logic [PEND_W-1:0]   m_pending_count,
    output logic [IDLE_W-1:0]   m_idle_count,
    output logic                m_last
);

    // classified request between front and back
    logic rq_valid;
    logic rq_ready;
    req_t rq_data;

    // front: accept, classify, buffer
    wtwd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_work_id   (s_work_id),
        .s_worker_id (s_worker_id),
        .rq_valid    (rq_valid),
        .rq_ready    (rq_ready),
        .rq_data     (rq_data)
    );

    // back: pending queue, idle stack, shutdown drain and result register
    wtwd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rq_valid        (rq_valid),
        .rq_ready        (rq_ready),
        .rq_data         (rq_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_work_out      (m_work_out),
        .m_worker_out    (m_worker_out),
        .m_pending_count (m_pending_count),
        .m_idle_count    (m_idle_count),
        .m_last          (m_last)
    );

endmodule

// ----- test/work_to_worker_dispatcher_test.sv -----
module work_to_worker_dispatcher_test;
    import wtwd_pkg::*;

    // run length and pacing
    localparam int DIRECTED_ROWS = 19;
    localparam int RANDOM_ITEMS  = 340;
    localparam int HOLD_AT_ITEM  = 120;     // receiver goes quiet around here
    localparam int DRAIN_AT_ITEM = 240;     // sender waits for an empty scoreboard here
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // one result beat as seen on the m_ channel
    typedef struct packed {
        ev_t                 ev;
        logic [WORK_W-1:0]   work;
        logic [WORKER_W-1:0] worker;
        logic [PEND_W-1:0]   pend;
        logic [IDLE_W-1:0]   idle;
        logic                last;
    } dispatch_result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        cmd_t                cmd;
        logic [WORK_W-1:0]   work;
        logic [WORKER_W-1:0] worker;
        logic                typed;
        dispatch_result_t    res;
    } directed_row_t;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command    = '0;
    logic [WORK_W-1:0]   s_work_id    = '0;
    logic [WORKER_W-1:0] s_worker_id  = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [EVENT_W-1:0]  m_event_res;
    logic [WORK_W-1:0]   m_work_out;
    logic [WORKER_W-1:0] m_worker_out;
    logic [PEND_W-1:0]   m_pending_count;
    logic [IDLE_W-1:0]   m_idle_count;
    logic                m_last;

    // shadow copy of the dispatcher: pending work fifo, idle worker stack, shutdown flag
    logic [WORK_W-1:0]   pend_work [QUEUE_DEPTH];
    int                  pend_len = 0;
    logic [WORKER_W-1:0] park_stack [WORKER_COUNT];
    int                  park_len = 0;
    bit                  is_shut  = 1'b0;

    dispatch_result_t    step_results [$];      // results of the request just accepted
    dispatch_result_t    expected_results [$];  // results still owed by the dut
    dispatch_result_t    seen_result;
    dispatch_result_t    owed_result;

    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    int                  burst_left     = 0;
    bit                  hold_off_req   = 1'b0;

    // directed table: empty-queue retract, queue ordering and retract of the first
    // match, assignment of the oldest work, duplicate parking, full stack, lifo dispatch
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_RETRACT, 8'h00, 3'd0, 1'b1, '{EV_REFUSED,    8'h00, 3'd0, 5'd0, 4'd0, 1'b1}},
        '{CMD_ADD,     8'h12, 3'd0, 1'b1, '{EV_QUEUED,     8'h12, 3'd0, 5'd1, 4'd0, 1'b1}},
        '{CMD_ADD,     8'hFF, 3'd7, 1'b0, '0},
        '{CMD_ADD,     8'h12, 3'd0, 1'b0, '0},
        '{CMD_RETRACT, 8'h12, 3'd0, 1'b1, '{EV_RETRACTED,  8'h12, 3'd0, 5'd2, 4'd0, 1'b1}},
        '{CMD_RETRACT, 8'h99, 3'd0, 1'b1, '{EV_REFUSED,    8'h99, 3'd0, 5'd2, 4'd0, 1'b1}},
        '{CMD_RETURN,  8'h00, 3'd7, 1'b1, '{EV_ASSIGNED,   8'hFF, 3'd7, 5'd1, 4'd0, 1'b1}},
        '{CMD_RETURN,  8'h00, 3'd0, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd0, 1'b0, '0},
        '{CMD_RETURN,  8'h55, 3'd0, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd1, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd2, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd3, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd4, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd5, 1'b0, '0},
        '{CMD_RETURN,  8'h00, 3'd6, 1'b0, '0},
        '{CMD_RETURN,  8'hAA, 3'd5, 1'b1, '{EV_DISMISSED,  8'h00, 3'd5, 5'd0, 4'd8, 1'b1}},
        '{CMD_ADD,     8'h00, 3'd0, 1'b1, '{EV_DISPATCHED, 8'h00, 3'd6, 5'd0, 4'd7, 1'b1}},
        '{CMD_ADD,     8'h80, 3'd0, 1'b0, '0}
    };

    work_to_worker_dispatcher dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_work_id       (s_work_id),
        .s_worker_id     (s_worker_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_work_out      (m_work_out),
        .m_worker_out    (m_worker_out),
        .m_pending_count (m_pending_count),
        .m_idle_count    (m_idle_count),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // hard stop if the dut hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic string fmt_result(input dispatch_result_t r);
        return $sformatf("ev=%0d work=%02h worker=%0d pend=%0d idle=%0d last=%0b",
                         r.ev, r.work, r.worker, r.pend, r.idle, r.last);
    endfunction

    task automatic log_fault(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endtask

    // ---------------------------------------------------------------------
    // dispatcher prediction
    // ---------------------------------------------------------------------

    task automatic record_event(input ev_t ev, input logic [WORK_W-1:0] w,
                                input logic [WORKER_W-1:0] k);
        dispatch_result_t r;
        r        = '0;
        r.ev     = ev;
        r.work   = w;
        r.worker = k;
        step_results.push_back(r);
    endtask

    // pull one entry out of the pending fifo, closing the gap behind it
    task automatic drop_pending(input int pos);
        int i;
        for (i = pos; i + 1 < pend_len; i++) begin
            pend_work[i] = pend_work[i + 1];
        end
        pend_len--;
    endtask

    // works out every result of one accepted request and updates the shadow state
    task automatic dispatch_predict(input cmd_t c, input logic [WORK_W-1:0] wid,
                                    input logic [WORKER_W-1:0] kid);
        logic [WORK_W-1:0] w;
        int                hit;
        int                i;
        step_results.delete();
        w   = wid & WORK_MASK;
        hit = -1;
        case (c)
            CMD_ADD: begin
                if (is_shut) begin
                    record_event(EV_ABANDONED, w, '0);
                end else if (park_len > 0) begin
                    // most recently parked worker takes it
                    park_len--;
                    record_event(EV_DISPATCHED, w, park_stack[park_len]);
                end else if (pend_len < QUEUE_DEPTH) begin
                    pend_work[pend_len] = w;
                    pend_len++;
                    record_event(EV_QUEUED, w, '0);
                end else begin
                    record_event(EV_REJECTED, w, '0);
                end
            end
            CMD_RETRACT: begin
                if (!is_shut) begin
                    for (i = 0; i < pend_len; i++) begin
                        if (hit < 0 && pend_work[i] == w) hit = i;
                    end
                end
                if (hit >= 0) begin
                    drop_pending(hit);
                    record_event(EV_RETRACTED, w, '0);
                end else begin
                    record_event(EV_REFUSED, w, '0);
                end
            end
            CMD_RETURN: begin
                if (is_shut) begin
                    record_event(EV_DISMISSED, '0, kid);
                end else if (pend_len > 0) begin
                    // oldest queued work goes to the returning worker
                    record_event(EV_ASSIGNED, pend_work[0], kid);
                    drop_pending(0);
                end else if (park_len < WORKER_COUNT) begin
                    park_stack[park_len] = kid;
                    park_len++;
                    record_event(EV_PARKED, '0, kid);
                end else begin
                    record_event(EV_DISMISSED, '0, kid);
                end
            end
            CMD_SHUTDOWN: begin
                // abandon queued work oldest first, then kill idle workers bottom up
                is_shut = 1'b1;
                for (i = 0; i < pend_len; i++) begin
                    record_event(EV_ABANDONED, pend_work[i], '0);
                end
                pend_len = 0;
                for (i = 0; i < park_len; i++) begin
                    record_event(EV_KILLED, '0, park_stack[i]);
                end
                park_len = 0;
                record_event(EV_SHUT_DONE, '0, '0);
            end
        endcase
        // counts reflect the state after the whole request
        for (i = 0; i < step_results.size(); i++) begin
            step_results[i].pend = PEND_W'(pend_len);
            step_results[i].idle = IDLE_W'(park_len);
            step_results[i].last = (i == step_results.size() - 1);
        end
    endtask

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    // offer one request and return at the edge where it is taken; bursts of
    // back-to-back requests are broken up by random gaps with s_valid low
    task automatic send_request(input cmd_t c, input logic [WORK_W-1:0] w,
                                input logic [WORKER_W-1:0] k);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_command   <= c;
        s_work_id   <= w;
        s_worker_id <= k;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue(input cmd_t c, input logic [WORK_W-1:0] w,
                         input logic [WORKER_W-1:0] k);
        send_request(c, w, k);
        dispatch_predict(c, w, k);
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    // drop valid and sit until every owed result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    // random request: fill phases lean on adds, drain phases on worker returns;
    // retracts mostly name an id that is really queued
    task automatic pick_request(input bit fill_phase, output cmd_t c,
                                output logic [WORK_W-1:0] w, output logic [WORKER_W-1:0] k);
        int roll;
        roll = $urandom_range(99);
        if (fill_phase) begin
            c = (roll < 70) ? CMD_ADD : (roll < 85) ? CMD_RETRACT : CMD_RETURN;
        end else begin
            c = (roll < 65) ? CMD_RETURN : (roll < 80) ? CMD_ADD : CMD_RETRACT;
        end
        w = ($urandom_range(3) == 0) ? WORK_W'($urandom_range(7)) : WORK_W'($urandom_range(255));
        k = WORKER_W'($urandom_range(WORKER_COUNT - 1));
        if (c == CMD_RETRACT && pend_len > 0 && $urandom_range(3) != 0) begin
            w = pend_work[$urandom_range(pend_len - 1)];
        end
    endtask

    initial begin
        cmd_t                c;
        logic [WORK_W-1:0]   w;
        logic [WORKER_W-1:0] k;
        bit                  fill_phase;
        int                  phase_left;

        fill_phase = 1'b0;
        phase_left = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].cmd, directed_rows[r].work, directed_rows[r].worker);
            dispatch_predict(directed_rows[r].cmd, directed_rows[r].work,
                             directed_rows[r].worker);
            if (directed_rows[r].typed) begin
                expected_results.push_back(directed_rows[r].res);
            end else begin
                foreach (step_results[i]) expected_results.push_back(step_results[i]);
            end
        end

        // random traffic, no shutdown since it sticks until reset
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                fill_phase = !fill_phase;
                phase_left = $urandom_range(15, 45);
            end
            phase_left--;
            if (n == HOLD_AT_ITEM) hold_off_req = 1'b1;
            if (n == DRAIN_AT_ITEM) wait_drained();
            pick_request(fill_phase, c, w, k);
            issue(c, w, k);
        end

        // fill the idle stack, overflow it, then shut down with every worker parked
        while (park_len < WORKER_COUNT) begin
            issue(CMD_RETURN, WORK_W'($urandom_range(255)),
                  WORKER_W'($urandom_range(WORKER_COUNT - 1)));
        end
        issue(CMD_RETURN, 8'h3C, 3'd3);
        issue(CMD_SHUTDOWN, 8'hFF, 3'd7);
        // everything after shutdown is turned away
        issue(CMD_ADD, 8'hC3, 3'd0);
        issue(CMD_RETRACT, 8'hC3, 3'd0);
        issue(CMD_RETURN, 8'h00, 3'd6);
        issue(CMD_SHUTDOWN, 8'h00, 3'd0);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    // receiver backpressure: always ready, random, or a rotating bit mask, with
    // one long hold-off on request from the sender to back the dut up
    initial begin
        int         phase_left;
        int         stall_mode;
        logic [7:0] stall_mask;
        phase_left = 0;
        stall_mode = 0;
        stall_mask = 8'hFF;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(16, 96);
                stall_mode = $urandom_range(2);
                stall_mask = 8'($urandom) | 8'h01;
            end
            phase_left--;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3) != 0);
                default: begin
                    m_ready    <= stall_mask[0];
                    stall_mask  = {stall_mask[0], stall_mask[7:1]};
                end
            endcase
            @(posedge aclk);
        end
    end

    // every result beat is matched against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.ev     = ev_t'(m_event_res);
            seen_result.work   = m_work_out;
            seen_result.worker = m_worker_out;
            seen_result.pend   = m_pending_count;
            seen_result.idle   = m_idle_count;
            seen_result.last   = m_last;
            if (expected_results.size() == 0) begin
                log_fault($sformatf("unexpected result: got %s", fmt_result(seen_result)));
            end else begin
                owed_result = expected_results.pop_front();
                if (seen_result !== owed_result) begin
                    log_fault($sformatf("result mismatch: expected %s, got %s",
                                        fmt_result(owed_result), fmt_result(seen_result)));
                end
            end
        end
    end

endmodule
